@@ design/lzss_pkg.sv @@
// Shared types and constants for the LZSS stream decompressor.
// No dependencies; the design files that use it refer to this package by scoped names.
package lzss_pkg;

  localparam int unsigned HistDepth    = 4096;
  localparam int unsigned HistAw       = $clog2(HistDepth);
  localparam int unsigned CmdFifoDepth = 4;
  localparam int unsigned CmdFifoAw    = $clog2(CmdFifoDepth);
  localparam int unsigned DistW        = 12;
  localparam int unsigned CntW         = 5;
  localparam int unsigned CountW       = 33;
  localparam int unsigned AddrW        = 3;

  // Register index carried in the word address bit of paddr.
  localparam logic RegExpectedLength = 1'b0;

  localparam logic [3:0]      FlagsPerGroup = 4'd8;
  // A pair copies nibble + 3 bytes, so its last byte index is nibble + 2.
  localparam logic [CntW-1:0] PairLastBias  = 5'd2;

  typedef struct packed {
    logic             is_lit;
    logic [7:0]       lit;
    logic [DistW-1:0] dist_m1;
    logic [CntW-1:0]  cnt_m1;
    logic             done;
    logic             mism;
  } cmd_t;

endpackage

@@ design/lzss_ram.sv @@
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module lzss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lzss_front.sv @@
// Front end: parses flag, literal and pair bytes, counts output bytes and
// pushes one command per producing byte. Depends on lzss_pkg.
module lzss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  output logic [31:0]                   expected_o,
  input  logic                          in_valid_i,
  input  logic [7:0]                    in_byte_i,
  output logic                          in_ready_o,
  input  logic                          cmd_full_i,
  output logic                          cmd_push_o,
  output lzss_pkg::cmd_t                cmd_o
);

  typedef enum logic {
    PH_UNIT,
    PH_PAIR
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [7:0]                        flag_bits_q, flag_bits_d;
  logic [3:0]                        flags_left_q, flags_left_d;
  logic [7:0]                        dist_low_q, dist_low_d;
  logic [lzss_pkg::CountW-1:0]       produced_q, produced_d;
  logic [31:0]                       expected_q, expected_d;
  logic                              accept;
  logic                              drop;
  logic [lzss_pkg::CountW-1:0]       add_n;
  logic [lzss_pkg::CountW-1:0]       new_count;
  logic [lzss_pkg::CountW-1:0]       expected_ext;

  assign in_ready_o   = !cmd_full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign expected_ext = {1'b0, expected_q};
  assign drop         = produced_q >= expected_ext;
  assign expected_o   = expected_q;

  assign add_n = (phase_q == PH_PAIR)
               ? lzss_pkg::CountW'(in_byte_i[3:0]) + lzss_pkg::CountW'(3)
               : lzss_pkg::CountW'(1);
  assign new_count = produced_q + add_n;

  always_comb begin
    phase_d       = phase_q;
    flag_bits_d   = flag_bits_q;
    flags_left_d  = flags_left_q;
    dist_low_d    = dist_low_q;
    produced_d    = produced_q;
    expected_d    = expected_q;
    cmd_push_o    = 1'b0;
    cmd_o.is_lit  = (phase_q == PH_UNIT);
    cmd_o.lit     = in_byte_i;
    cmd_o.dist_m1 = {in_byte_i[7:4], dist_low_q};
    cmd_o.cnt_m1  = (phase_q == PH_PAIR)
                  ? lzss_pkg::CntW'(in_byte_i[3:0]) + lzss_pkg::PairLastBias
                  : '0;
    cmd_o.done    = new_count >= expected_ext;
    cmd_o.mism    = new_count > expected_ext;

    if (cfg_we_i) begin
      // A new job restarts parsing and counting; the history is kept.
      expected_d   = cfg_wdata_i;
      phase_d      = PH_UNIT;
      flag_bits_d  = '0;
      flags_left_d = '0;
      dist_low_d   = '0;
      produced_d   = '0;
    end else if (accept && !drop) begin
      case (phase_q)
        PH_UNIT: begin
          if (flags_left_q == '0) begin
            flag_bits_d  = in_byte_i;
            flags_left_d = lzss_pkg::FlagsPerGroup;
          end else if (flag_bits_q[0]) begin
            cmd_push_o   = 1'b1;
            produced_d   = new_count;
            flag_bits_d  = flag_bits_q >> 1;
            flags_left_d = flags_left_q - 4'd1;
          end else begin
            dist_low_d = in_byte_i;
            phase_d    = PH_PAIR;
          end
        end
        PH_PAIR: begin
          cmd_push_o   = 1'b1;
          produced_d   = new_count;
          flag_bits_d  = flag_bits_q >> 1;
          flags_left_d = flags_left_q - 4'd1;
          phase_d      = PH_UNIT;
        end
        default: begin
          phase_d = PH_UNIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_UNIT;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      dist_low_q   <= '0;
      produced_q   <= '0;
      expected_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      dist_low_q   <= dist_low_d;
      produced_q   <= produced_d;
      expected_q   <= expected_d;
    end
  end

endmodule

@@ design/lzss_cmd_fifo.sv @@
// Short command queue between the parsing front end and the copy engine.
// Depends on lzss_pkg.
module lzss_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzss_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lzss_pkg::cmd_t rdata_o
);

  lzss_pkg::cmd_t                  entries_q [lzss_pkg::CmdFifoDepth];
  logic [lzss_pkg::CmdFifoAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lzss_pkg::CmdFifoAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lzss_pkg::CmdFifoAw:0]    count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = count_q == (lzss_pkg::CmdFifoAw+1)'(lzss_pkg::CmdFifoDepth);
  assign valid_o = count_q != '0;
  assign rdata_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ design/lzss_back.sv @@
// Copy engine: expands commands into output bytes, one per cycle unless output
// stalls, reading and writing the history RAM. Depends on lzss_pkg.
module lzss_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        new_job_i,
  input  logic                        cmd_valid_i,
  input  lzss_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        ram_we_o,
  output logic [lzss_pkg::HistAw-1:0] ram_waddr_o,
  output logic [7:0]                  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [lzss_pkg::HistAw-1:0] ram_raddr_o,
  input  logic [7:0]                  ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        last_of_run_o,
  output logic                        job_done_o,
  output logic                        length_mismatch_o
);

  // Issue stage
  logic [lzss_pkg::CntW-1:0]   k_q, k_d;
  logic [lzss_pkg::HistAw-1:0] issue_ptr_q, issue_ptr_d;
  logic                        issue;
  logic                        cmd_last;
  logic                        fwd_last;
  // Byte stage, in the cycle after the RAM read is issued
  logic                        b_valid_q, b_valid_d;
  logic                        b_lit_q;
  logic                        b_use_last_q;
  logic [7:0]                  b_byte_q;
  logic                        b_last_q;
  logic                        b_done_q;
  logic                        b_mism_q;
  logic                        b_fire;
  logic [7:0]                  b_data;
  logic [lzss_pkg::HistAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [7:0]                  last_byte_q;
  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q;
  logic                        out_done_q;
  logic                        out_mism_q;

  assign b_fire   = b_valid_q && (!out_valid_q || out_ready_i);
  assign issue    = cmd_valid_i && (!b_valid_q || b_fire);
  assign cmd_last = k_q == cmd_i.cnt_m1;
  assign cmd_pop_o = issue && cmd_last;

  // At distance one the source is the byte written just before. While that
  // byte is still in the byte stage it is not yet in the RAM, so it comes
  // from a holding register instead.
  assign fwd_last    = (cmd_i.dist_m1 == '0) && b_valid_q;
  assign ram_re_o    = issue && !cmd_i.is_lit && !fwd_last;
  assign ram_raddr_o = issue_ptr_q - lzss_pkg::HistAw'(cmd_i.dist_m1) - 1'b1;

  assign b_data = b_lit_q ? b_byte_q : (b_use_last_q ? last_byte_q : ram_rdata_i);

  assign ram_we_o    = b_fire;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = b_data;

  always_comb begin
    k_d         = k_q;
    issue_ptr_d = issue_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    b_valid_d   = b_valid_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (b_fire) begin
      out_valid_d = 1'b1;
      wr_ptr_d    = wr_ptr_q + 1'b1;
      b_valid_d   = 1'b0;
    end
    if (issue) begin
      b_valid_d   = 1'b1;
      issue_ptr_d = issue_ptr_q + 1'b1;
      k_d         = cmd_last ? '0 : k_q + 1'b1;
    end
    if (new_job_i) begin
      k_d         = '0;
      issue_ptr_d = '0;
      wr_ptr_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      issue_ptr_q <= '0;
      wr_ptr_q    <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      issue_ptr_q <= issue_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_lit_q      <= cmd_i.is_lit;
      b_use_last_q <= fwd_last;
      b_byte_q     <= cmd_i.lit;
      b_last_q     <= cmd_last;
      b_done_q     <= cmd_i.done;
      b_mism_q     <= cmd_i.mism;
    end
    if (b_fire) begin
      last_byte_q <= b_data;
      out_byte_q  <= b_data;
      out_last_q  <= b_last_q;
      out_done_q  <= b_done_q;
      out_mism_q  <= b_mism_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign last_of_run_o     = out_last_q;
  assign job_done_o        = out_done_q;
  assign length_mismatch_o = out_mism_q;

endmodule

@@ design/lzss_stream_decompressor_unit.sv @@
// LZSS stream decompressor, 4096-byte history. Accepts one compressed byte per
// cycle while the command queue has room; a literal or pair passes the command
// queue, byte stage and output register before its first result, then one byte
// per cycle while output is taken. A pair of n bytes (3 to 18) holds the copy
// engine until all are issued. Reset clears all control state; the history RAM
// is not reset and is undefined until written. Depends on lzss_pkg, submodules.
module lzss_stream_decompressor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lzss_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  output logic                       job_done_o,
  output logic                       length_mismatch_o
);

  logic                        cfg_we;
  logic [31:0]                 expected;
  logic                        push;
  lzss_pkg::cmd_t              push_cmd;
  logic                        fifo_full;
  logic                        fifo_valid;
  lzss_pkg::cmd_t              fifo_cmd;
  logic                        pop;
  logic                        ram_we;
  logic [lzss_pkg::HistAw-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic                        ram_re;
  logic [lzss_pkg::HistAw-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == lzss_pkg::RegExpectedLength);
  assign prdata = (paddr[2] == lzss_pkg::RegExpectedLength) ? expected : '0;

  lzss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata),
    .expected_o  (expected),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .in_ready_o  (in_ready_o),
    .cmd_full_i  (fifo_full),
    .cmd_push_o  (push),
    .cmd_o       (push_cmd)
  );

  lzss_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (fifo_cmd)
  );

  lzss_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .new_job_i         (cfg_we),
    .cmd_valid_i       (fifo_valid),
    .cmd_i             (fifo_cmd),
    .cmd_pop_o         (pop),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .last_of_run_o     (last_of_run_o),
    .job_done_o        (job_done_o),
    .length_mismatch_o (length_mismatch_o)
  );

  lzss_ram #(
    .Width (8),
    .Depth (lzss_pkg::HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ sim/lzss_stream_decompressor_unit_tb.sv @@
// Self-checking testbench for the LZSS stream decompressor unit.
// Drives compressed bytes and APB length writes, predicts every output byte.
// Depends on lzss_pkg and lzss_stream_decompressor_unit.
`timescale 1ns / 1ps

module lzss_stream_decompressor_unit_tb;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam logic [lzss_pkg::AddrW-1:0] ExpLenAddr = {lzss_pkg::RegExpectedLength, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       mism;
  } dec_byte_t;

  typedef enum bit {PhaseUnit, PhasePairHi} stream_phase_e;

  class decomp_scoreboard;
    bit [7:0]                    ring    [lzss_pkg::HistDepth];
    bit                          written [lzss_pkg::HistDepth];
    bit [31:0]                   exp_len;
    bit [7:0]                    flag_bits;
    bit [3:0]                    flags_left;
    stream_phase_e               phase;
    bit [7:0]                    dist_low;
    bit [32:0]                   produced;
    bit [lzss_pkg::HistAw-1:0]   wptr;
    dec_byte_t                   fresh[$];
    dec_byte_t                   pending[$];
    int                          error_count;

    function new();
      exp_len = '0;
      error_count = 0;
      set_length('0);
    endfunction

    function void set_length(bit [31:0] value);
      exp_len    = value;
      flag_bits  = '0;
      flags_left = '0;
      phase      = PhaseUnit;
      dist_low   = '0;
      produced   = '0;
      wptr       = '0;
    endfunction

    function void store_byte(bit [7:0] b);
      ring[wptr]    = b;
      written[wptr] = 1'b1;
      wptr          = wptr + 1'b1;
      produced      = produced + 1'b1;
      fresh.push_back('{data: b, last: 1'b0, done: 1'b0, mism: 1'b0});
    endfunction

    function void note_request(bit [7:0] b);
      bit [lzss_pkg::DistW-1:0]  dist_m1;
      bit [lzss_pkg::HistAw-1:0] src;
      int                        count;
      if (produced >= exp_len) return;
      if (phase == PhaseUnit) begin
        if (flags_left == 0) begin
          flag_bits  = b;
          flags_left = lzss_pkg::FlagsPerGroup;
          return;
        end
        if (!flag_bits[0]) begin
          dist_low = b;
          phase    = PhasePairHi;
          return;
        end
        store_byte(b);
      end else begin
        dist_m1 = {b[7:4], dist_low};
        count   = int'(b[3:0]) + 3;
        // The copy goes byte by byte, so a short distance repeats bytes of this copy.
        repeat (count) begin
          src = wptr - dist_m1 - 1'b1;
          store_byte(ring[src]);
        end
        phase = PhaseUnit;
      end
      flag_bits = flag_bits >> 1;
      if (flags_left > 0) flags_left = flags_left - 1'b1;
      foreach (fresh[i]) begin
        fresh[i].done = (produced >= exp_len);
        fresh[i].mism = (produced > exp_len);
        fresh[i].last = (i == fresh.size() - 1);
        pending.push_back(fresh[i]);
      end
      fresh.delete();
    endfunction

    function void check_result(dec_byte_t got);
      dec_byte_t want;
      if (pending.size() == 0) begin
        $error("out_byte: nothing expected, got %0h", got.data);
        error_count++;
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, got.data);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
        error_count++;
      end
      if (got.done !== want.done) begin
        $error("job_done: expected %0b, got %0b", want.done, got.done);
        error_count++;
      end
      if (got.mism !== want.mism) begin
        $error("length_mismatch: expected %0b, got %0b", want.mism, got.mism);
        error_count++;
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [lzss_pkg::AddrW-1:0] paddr       = '0;
  logic [31:0]                pwdata      = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [7:0]                 in_byte_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [7:0]                 out_byte_o;
  logic                       last_of_run_o;
  logic                       job_done_o;
  logic                       length_mismatch_o;

  decomp_scoreboard           sb = new();
  bit                         tx_burst     = 1'b0;
  bit                         rx_burst     = 1'b0;
  bit                         hold_request = 1'b0;
  int                         random_items = 0;
  int unsigned                cycle_count  = 0;
  logic [lzss_pkg::DistW-1:0] pair_dist    = '0;
  logic [3:0]                 pair_len     = '0;

  lzss_stream_decompressor_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .last_of_run_o     (last_of_run_o),
    .job_done_o        (job_done_o),
    .length_mismatch_o (length_mismatch_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({out_byte_o, last_of_run_o, job_done_o, length_mismatch_o});
    end
  end

  // Output side: a random stall before each byte, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    wait (rst_ni);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic bit history_ready(logic [lzss_pkg::DistW-1:0] dist_m1, int count);
    int                        span;
    bit [lzss_pkg::HistAw-1:0] src;
    span = (count < int'(dist_m1) + 1) ? count : int'(dist_m1) + 1;
    for (int i = 0; i < span; i++) begin
      src = sb.wptr - dist_m1 - 1'b1 + i[lzss_pkg::HistAw-1:0];
      if (!sb.written[src]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Picks a pair that only reads history written since reset. Distance one is
  // always safe once the job has emitted its first byte.
  function automatic void choose_pair();
    logic [lzss_pkg::DistW-1:0] cand;
    int                         count;
    case ($urandom_range(0, 3))
      0: pair_len = 4'hF;
      1: pair_len = 4'h0;
      default: pair_len = 4'($urandom);
    endcase
    count = int'(pair_len) + 3;
    pair_dist = '0;
    for (int t = 0; t < 8; t++) begin
      case ($urandom_range(0, 3))
        0: cand = 12'($urandom_range(0, 3));
        1: cand = 12'($urandom_range(0, 63));
        default: cand = 12'($urandom);
      endcase
      if (history_ready(cand, count)) begin
        pair_dist = cand;
        break;
      end
    end
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [7:0] b;
    if (sb.produced >= sb.exp_len) return 8'($urandom);
    if (sb.phase == PhasePairHi) return {pair_dist[11:8], pair_len};
    if (sb.flags_left == 0) begin
      case ($urandom_range(0, 3))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      // With no history written behind the write pointer, the next unit is made a literal.
      if (!sb.written[sb.wptr - 1'b1]) b[0] = 1'b1;
      return b;
    end
    if (sb.flag_bits[0]) return 8'($urandom);
    choose_pair();
    return pair_dist[7:0];
  endfunction

  task automatic apb_write(input logic [lzss_pkg::AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_expected_length(input logic [31:0] value);
    apb_write(ExpLenAddr, value);
    sb.set_length(value);
  endtask

  task automatic send_request(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(b);
  endtask

  task automatic send_list(input logic [7:0] stream[$]);
    foreach (stream[i]) send_request(stream[i]);
  endtask

  // Flag bytes and first pair bytes leave no output, so the block may still be
  // busy after the last expected byte; give it time before touching the register.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random_job(input logic [31:0] len, input int cap);
    int sent;
    int extra;
    set_expected_length(len);
    sent = 0;
    while (sb.produced < sb.exp_len && sent < cap) begin
      random_items++;
      sent++;
      send_request(next_stream_byte());
    end
    extra = $urandom_range(1, 3);
    repeat (extra) send_request(next_stream_byte());
    settle_block();
  endtask

  initial begin : stimulus
    logic [7:0] stream[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The expected length is zero after reset, so these are dropped.
    stream = '{8'h3C, 8'hC3};
    send_list(stream);
    settle_block();
    set_expected_length(32'd0);
    stream = '{8'hFF};
    send_list(stream);
    settle_block();

    // Literals at both extremes, a longest pair at distance one, a shortest pair
    // back to the first byte, then a copy that overshoots the length of 30.
    set_expected_length(32'd30);
    stream = '{8'h27, 8'h00, 8'hFF, 8'hA5, 8'h00, 8'h0F, 8'h14, 8'h00,
               8'h5A, 8'h02, 8'h0F, 8'h12, 8'h34};
    send_list(stream);
    settle_block();

    // Exact end of job on a single literal.
    set_expected_length(32'd1);
    stream = '{8'h01, 8'h7E, 8'h99};
    send_list(stream);
    settle_block();

    // Largest distance reads history left by the earlier jobs.
    set_expected_length(32'hFFFF_FFFF);
    stream = '{8'h01, 8'h80, 8'hFF, 8'hF0};
    send_list(stream);
    settle_block();

    // Back-to-back input while the output side holds off fills the block up.
    tx_burst = 1'b1;
    hold_request = 1'b1;
    run_random_job(32'd3000, 80);

    while (random_items < RandomItems) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: run_random_job(32'd0, 4);
        1: run_random_job($urandom() | 32'h8000_0000, 60);
        default: run_random_job($urandom_range(1, 400), 120);
      endcase
    end

    settle_block();
    if (sb.error_count == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
